[hdl/dtb_pkg.sv]
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types, constants and helpers for the double-tap button qualifier.
// ----------------------------------------------------------------------------
package dtb_pkg;

   localparam int TIME_BITS  = 32;
   localparam int COORD_BITS = 16;
   localparam int FUNC_W     = 3;
   localparam int PID_W      = 4;
   localparam int EVENT_W    = 2;
   localparam int CODE_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DRIFT_DIVISOR = 20;
   localparam int DRIFT_LIMIT   = ((1 << COORD_BITS) + DRIFT_DIVISOR - 1) / DRIFT_DIVISOR;

   localparam logic [TIME_BITS-1:0] HOLD_START_MS   = TIME_BITS'(500);
   localparam logic [TIME_BITS-1:0] REPEAT_EVERY_MS = TIME_BITS'(150);
   localparam logic [TIME_BITS-1:0] TAP_WINDOW_MS   = TIME_BITS'(200);

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DOWN    = 3'd0,
      FUNC_UP      = 3'd1,
      FUNC_MOVE    = 3'd2,
      FUNC_TICK    = 3'd3,
      FUNC_RELEASE = 3'd4
   } func_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 2'd0,
      EV_DOWN   = 2'd1,
      EV_UP     = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      TAP_IDLE     = 2'd0,
      TAP_PRESS1   = 2'd1,
      TAP_RELEASE1 = 2'd2,
      TAP_PRESS2   = 2'd3
   } tap_phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RECT_LEFT     = 3'd0,
      CSR_RECT_TOP      = 3'd1,
      CSR_RECT_RIGHT    = 3'd2,
      CSR_RECT_BOTTOM   = 3'd3,
      CSR_BUTTON_CODE   = 3'd4,
      CSR_REPEAT_ENABLE = 3'd5,
      CSR_HIDDEN        = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] rect_left;
      logic [COORD_BITS-1:0] rect_top;
      logic [COORD_BITS-1:0] rect_right;
      logic [COORD_BITS-1:0] rect_bottom;
      logic [CODE_W-1:0]     button_code;
      logic                  repeat_enable;
      logic                  hidden;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [PID_W-1:0]      pointer_id;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      logic               handled;
      logic [EVENT_W-1:0] event_res;
      logic [CODE_W-1:0]  code;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   function automatic rsp_item_type make_rsp(input logic handled, input event_type ev,
                                             input logic last,
                                             input logic [CODE_W-1:0] code);
      rsp_item_type r;
      r.handled   = handled;
      r.event_res = ev;
      r.code      = (ev != EV_NONE) ? code : '0;
      r.last      = last;
      return r;
   endfunction

endpackage

[hdl/dtb_if.sv]
// ----------------------------------------------------------------------------
// dtb_req_if / dtb_rsp_if
// Valid/ready channels for pointer requests and button results.
// ----------------------------------------------------------------------------
interface dtb_req_if;
   import dtb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [PID_W-1:0]      pointer_id;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [TIME_BITS-1:0]  now_ms;

   modport source(output valid, func, pointer_id, pos_x, pos_y, now_ms, input ready);
   modport sink(input valid, func, pointer_id, pos_x, pos_y, now_ms, output ready);
endinterface

interface dtb_rsp_if;
   import dtb_pkg::*;
   logic               valid;
   logic               ready;
   logic               handled;
   logic [EVENT_W-1:0] event_res;
   logic [CODE_W-1:0]  code;
   logic               last;

   modport source(output valid, handled, event_res, code, last, input ready);
   modport sink(input valid, handled, event_res, code, last, output ready);
endinterface

[hdl/dtb_req_stage.sv]
// ----------------------------------------------------------------------------
// dtb_req_stage
// Input register: captures one request and holds it until it is processed.
// ----------------------------------------------------------------------------
module dtb_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   dtb_req_if.sink               req_ch,
   input  logic                  advance,
   output logic                  item_valid,
   output dtb_pkg::req_item_type item
);
   import dtb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.func       <= req_ch.func;
         item_ff.pointer_id <= req_ch.pointer_id;
         item_ff.pos_x      <= req_ch.pos_x;
         item_ff.pos_y      <= req_ch.pos_y;
         item_ff.now_ms     <= req_ch.now_ms;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/dtb_qualifier.sv]
// ----------------------------------------------------------------------------
// dtb_qualifier
// Button state (holder, tap tracker, repeat deadline) and result generation.
// ----------------------------------------------------------------------------
module dtb_qualifier (
   input  logic                  clock,
   input  logic                  reset,
   input  dtb_pkg::cfg_type      cfg,
   input  logic                  fire,
   input  dtb_pkg::req_item_type item,
   output dtb_pkg::rsp_push_type push
);
   import dtb_pkg::*;

   logic                  held_ff, held_in;
   logic [PID_W-1:0]      holder_id_ff, holder_id_in;
   tap_phase_type         tap_phase_ff, tap_phase_in;
   logic [TIME_BITS-1:0]  tap_time_ff, tap_time_in;
   logic [COORD_BITS-1:0] tap_x_ff, tap_x_in;
   logic [COORD_BITS-1:0] tap_y_ff, tap_y_in;
   logic [TIME_BITS-1:0]  repeat_due_ff, repeat_due_in;

   func_type              func;
   logic                  masked;
   logic                  in_rect;
   logic [COORD_BITS-1:0] dx, dy;
   logic [COORD_BITS:0]   drift;
   logic                  small_drift;
   logic [TIME_BITS-1:0]  tap_dt;
   logic                  in_window;
   logic [TIME_BITS-1:0]  rep_dt;
   logic                  repeat_due;
   logic                  holder_up;
   logic                  tap_ok;

   assign func    = func_type'(item.func);
   assign masked  = cfg.hidden && (func inside {FUNC_DOWN, FUNC_UP, FUNC_MOVE});
   assign in_rect = (item.pos_x >= cfg.rect_left) && (item.pos_x <= cfg.rect_right) &&
                    (item.pos_y >= cfg.rect_top)  && (item.pos_y <= cfg.rect_bottom);

   assign dx          = (item.pos_x > tap_x_ff) ? item.pos_x - tap_x_ff : tap_x_ff - item.pos_x;
   assign dy          = (item.pos_y > tap_y_ff) ? item.pos_y - tap_y_ff : tap_y_ff - item.pos_y;
   assign drift       = {1'b0, dx} + {1'b0, dy};
   assign small_drift = drift < (COORD_BITS+1)'(DRIFT_LIMIT);

   assign tap_dt    = item.now_ms - tap_time_ff;
   assign in_window = (tap_dt < TAP_WINDOW_MS) || tap_dt[TIME_BITS-1];
   assign tap_ok    = in_window && small_drift;

   assign rep_dt     = item.now_ms - repeat_due_ff;
   assign repeat_due = cfg.repeat_enable && held_ff && (rep_dt != '0) && !rep_dt[TIME_BITS-1];

   assign holder_up = held_ff && (item.pointer_id == holder_id_ff);

   always_comb begin
      tap_phase_in = tap_phase_ff;
      if (fire && !masked) begin
         case (func)
            FUNC_DOWN: begin
               if (in_rect) begin
                  if (tap_phase_ff == TAP_RELEASE1) begin
                     tap_phase_in = tap_ok ? TAP_PRESS2 : TAP_PRESS1;
                  end else if (tap_phase_ff == TAP_IDLE) begin
                     tap_phase_in = TAP_PRESS1;
                  end
               end
            end
            FUNC_UP: begin
               if (holder_up && in_rect) begin
                  if (tap_phase_ff == TAP_PRESS1) begin
                     tap_phase_in = tap_ok ? TAP_RELEASE1 : TAP_IDLE;
                  end else if (tap_phase_ff == TAP_PRESS2) begin
                     tap_phase_in = TAP_IDLE;
                  end
               end
            end
            default: begin
               tap_phase_in = tap_phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      held_in       = held_ff;
      holder_id_in  = holder_id_ff;
      tap_time_in   = tap_time_ff;
      tap_x_in      = tap_x_ff;
      tap_y_in      = tap_y_ff;
      repeat_due_in = repeat_due_ff;
      push.count    = 2'd0;
      push.item0    = make_rsp(1'b0, EV_NONE, 1'b1, cfg.button_code);
      push.item1    = make_rsp(1'b0, EV_NONE, 1'b1, cfg.button_code);
      if (fire) begin
         push.count = 2'd1;
         if (!masked) begin
            case (func)
               FUNC_DOWN: begin
                  if (in_rect) begin
                     held_in       = 1'b1;
                     holder_id_in  = item.pointer_id;
                     repeat_due_in = item.now_ms + HOLD_START_MS;
                     if (tap_phase_ff == TAP_IDLE ||
                         (tap_phase_ff == TAP_RELEASE1 && !tap_ok)) begin
                        tap_time_in = item.now_ms;
                        tap_x_in    = item.pos_x;
                        tap_y_in    = item.pos_y;
                     end
                     push.item0 = make_rsp(1'b1, EV_DOWN, 1'b1, cfg.button_code);
                  end
               end
               FUNC_UP: begin
                  if (holder_up) begin
                     held_in    = 1'b0;
                     push.item0 = make_rsp(1'b1, EV_UP, 1'b1, cfg.button_code);
                     if (in_rect) begin
                        if (tap_phase_ff == TAP_PRESS1 && tap_ok) begin
                           tap_time_in = item.now_ms;
                        end else if (tap_phase_ff == TAP_PRESS2) begin
                           tap_time_in = '0;
                           if (small_drift) begin
                              push.count = 2'd2;
                              push.item0 = make_rsp(1'b1, EV_UP, 1'b0, cfg.button_code);
                              push.item1 = make_rsp(1'b1, EV_DOUBLE, 1'b1,
                                                    cfg.button_code);
                           end
                        end
                     end
                  end
               end
               FUNC_TICK: begin
                  if (repeat_due) begin
                     repeat_due_in = item.now_ms + REPEAT_EVERY_MS;
                     push.count    = 2'd2;
                     push.item0    = make_rsp(1'b0, EV_DOWN, 1'b0, cfg.button_code);
                     push.item1    = make_rsp(1'b0, EV_UP, 1'b1, cfg.button_code);
                  end
               end
               FUNC_RELEASE: begin
                  held_in    = 1'b0;
                  push.item0 = make_rsp(1'b0, EV_UP, 1'b1, cfg.button_code);
               end
               default: begin
                  push.item0 = make_rsp(1'b0, EV_NONE, 1'b1, cfg.button_code);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         holder_id_ff  <= '0;
         tap_phase_ff  <= TAP_IDLE;
         tap_time_ff   <= '0;
         tap_x_ff      <= '0;
         tap_y_ff      <= '0;
         repeat_due_ff <= '0;
      end else begin
         held_ff       <= held_in;
         holder_id_ff  <= holder_id_in;
         tap_phase_ff  <= tap_phase_in;
         tap_time_ff   <= tap_time_in;
         tap_x_ff      <= tap_x_in;
         tap_y_ff      <= tap_y_in;
         repeat_due_ff <= repeat_due_in;
      end
   end

endmodule

[hdl/dtb_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// dtb_rsp_fifo
// Four-entry result queue: takes up to two results a cycle, drives the result
// channel one result a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module dtb_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  dtb_pkg::rsp_push_type push,
   output logic                  space_ok,
   dtb_rsp_if.source             rsp_ch
);
   import dtb_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   rsp_item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 pop;
   logic [PTR_W-1:0]     wr_ptr_next;
   rsp_item_type         head;

   assign head        = mem_ff[rd_ptr_ff];
   assign pop         = rsp_ch.valid && rsp_ch.ready;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign space_ok    = count_ff <= (PTR_W+1)'(DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.item1;
      end
   end

   assign rsp_ch.valid     = count_ff != '0;
   assign rsp_ch.handled   = head.handled;
   assign rsp_ch.event_res = head.event_res;
   assign rsp_ch.code      = head.code;
   assign rsp_ch.last      = head.last;

endmodule

[hdl/double_tap_button_detector_core.sv]
// ----------------------------------------------------------------------------
// double_tap_button_detector_core
// Touch button qualifier with double-tap detection and auto-repeat.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the four-entry result queue has room
// for two results. It is registered at the input, evaluated combinationally
// against the button state and pushed into the result queue, from which its
// results are driven onto the result channel. The result channel carries one
// result per cycle while the receiver is ready: a request with one result
// sustains one request per cycle, while an up that completes a double tap or
// a repeat tick puts two results on the result channel. Register writes take
// effect at the next clock edge.
module double_tap_button_detector_core (
   input  logic                           clock,
   input  logic                           reset,
   dtb_req_if.sink                        req_ch,
   dtb_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [dtb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dtb_pkg::*;

   cfg_type      cfg_ff;
   logic         item_valid;
   req_item_type item;
   logic         space_ok;
   logic         advance;
   rsp_push_type push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rect_left     <= '0;
         cfg_ff.rect_top      <= '0;
         cfg_ff.rect_right    <= COORD_MAX;
         cfg_ff.rect_bottom   <= COORD_MAX;
         cfg_ff.button_code   <= '0;
         cfg_ff.repeat_enable <= 1'b0;
         cfg_ff.hidden        <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RECT_LEFT:     cfg_ff.rect_left     <= csr_wdata[COORD_BITS-1:0];
            CSR_RECT_TOP:      cfg_ff.rect_top      <= csr_wdata[COORD_BITS-1:0];
            CSR_RECT_RIGHT:    cfg_ff.rect_right    <= csr_wdata[COORD_BITS-1:0];
            CSR_RECT_BOTTOM:   cfg_ff.rect_bottom   <= csr_wdata[COORD_BITS-1:0];
            CSR_BUTTON_CODE:   cfg_ff.button_code   <= csr_wdata[CODE_W-1:0];
            CSR_REPEAT_ENABLE: cfg_ff.repeat_enable <= csr_wdata[0];
            CSR_HIDDEN:        cfg_ff.hidden        <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign advance = item_valid && space_ok;

   dtb_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dtb_qualifier u_qualifier (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .fire  (advance),
      .item  (item),
      .push  (push)
   );

   dtb_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_ch   (rsp_ch)
   );

endmodule

[hdl/dtb_checker.sv]
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks on request/result ordering and result contents.
// ----------------------------------------------------------------------------
module dtb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_handled,
   input logic [dtb_pkg::EVENT_W-1:0]  rsp_event_res,
   input logic [dtb_pkg::CODE_W-1:0]   rsp_code,
   input logic                         rsp_last
);
   import dtb_pkg::*;

   logic [3:0] open_ff;
   logic       req_take;
   logic       rsp_done;

   assign req_take = req_valid && req_ready;
   assign rsp_done = rsp_valid && rsp_ready && rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 4'(req_take) - 4'(rsp_done);
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 4'd0)
      else $error("result without an open request");

   a_handled_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_handled || rsp_event_res == EV_DOUBLE) |->
         rsp_event_res != EV_NONE && (rsp_event_res != EV_DOUBLE || rsp_last))
      else $error("handled result without event or double tap not last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) &&
         $stable(rsp_code) && $stable(rsp_last) && $stable(rsp_handled))
      else $error("stalled result changed");

endmodule

bind double_tap_button_detector_core dtb_checker u_dtb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_handled   (rsp_ch.handled),
   .rsp_event_res (rsp_ch.event_res),
   .rsp_code      (rsp_ch.code),
   .rsp_last      (rsp_ch.last)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-tap button qualifier.
// A short table of directed requests and register writes is followed by
// random tap, hold and noise sequences under several button settings. Each
// accepted request runs through a behavioral copy of the button, and every
// result is compared field by field, in order, with the predicted events.
// Both channels idle at random; one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
module testbench;
   import dtb_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 90;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   typedef struct {
      bit            is_csr;
      csr_reg_type   reg_idx;
      logic [15:0]   value;
      req_item_type  req;
      bit            typed;
      rsp_item_type  rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dtb_req_if req_if();
   dtb_rsp_if rsp_if();

   double_tap_button_detector_core dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // button state as seen from the pins
   cfg_type button_cfg;
   bit button_held;
   logic [PID_W-1:0] holder_pid;
   tap_phase_type tap_state;
   logic [TIME_BITS-1:0] first_tap_ms;
   logic [COORD_BITS-1:0] first_tap_x;
   logic [COORD_BITS-1:0] first_tap_y;
   logic [TIME_BITS-1:0] repeat_at_ms;

   rsp_item_type awaited_events[$];
   directed_row_type directed_rows[$];
   int unsigned failures = 0;
   int unsigned requests_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit hold_off_request = 1'b0;
   bit no_idle = 1'b0;
   logic [TIME_BITS-1:0] wall_ms;

   function automatic rsp_item_type button_event(input logic hnd, input event_type ev,
                                                 input logic fin);
      rsp_item_type r;
      r.handled   = hnd;
      r.event_res = ev;
      r.code      = (ev != EV_NONE) ? button_cfg.button_code : '0;
      r.last      = fin;
      return r;
   endfunction

   function automatic rsp_item_type fixed_event(input logic hnd, input event_type ev,
                                                input logic [CODE_W-1:0] code);
      rsp_item_type r;
      r.handled   = hnd;
      r.event_res = ev;
      r.code      = code;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic bit tap_in_window(input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] lag;
      lag = now - first_tap_ms;
      return lag < TAP_WINDOW_MS || lag[TIME_BITS-1];
   endfunction

   function automatic bit tap_near(input logic [COORD_BITS-1:0] x,
                                   input logic [COORD_BITS-1:0] y);
      int unsigned spread;
      spread = (x > first_tap_x ? x - first_tap_x : first_tap_x - x)
             + (y > first_tap_y ? y - first_tap_y : first_tap_y - y);
      return spread * DRIFT_DIVISOR < (1 << COORD_BITS);
   endfunction

   function automatic int unsigned qualify_request(input req_item_type it,
                                                   output rsp_item_type first,
                                                   output rsp_item_type second);
      logic [TIME_BITS-1:0] lag;
      bit in_rect;
      bit doubled;
      first  = button_event(1'b0, EV_NONE, 1'b1);
      second = first;
      in_rect = it.pos_x >= button_cfg.rect_left && it.pos_x <= button_cfg.rect_right
             && it.pos_y >= button_cfg.rect_top && it.pos_y <= button_cfg.rect_bottom;
      if (button_cfg.hidden && it.func <= FUNC_MOVE)
         return 1;
      case (it.func)
         FUNC_DOWN: begin
            if (in_rect) begin
               button_held  = 1'b1;
               holder_pid   = it.pointer_id;
               repeat_at_ms = it.now_ms + HOLD_START_MS;
               if (tap_state == TAP_RELEASE1)
                  tap_state = (tap_in_window(it.now_ms) && tap_near(it.pos_x, it.pos_y))
                            ? TAP_PRESS2 : TAP_IDLE;
               if (tap_state == TAP_IDLE) begin
                  tap_state    = TAP_PRESS1;
                  first_tap_ms = it.now_ms;
                  first_tap_x  = it.pos_x;
                  first_tap_y  = it.pos_y;
               end
               first = button_event(1'b1, EV_DOWN, 1'b1);
            end
         end
         FUNC_UP: begin
            if (button_held && it.pointer_id == holder_pid) begin
               doubled     = 1'b0;
               button_held = 1'b0;
               if (in_rect) begin
                  if (tap_state == TAP_PRESS1) begin
                     if (tap_in_window(it.now_ms) && tap_near(it.pos_x, it.pos_y)) begin
                        tap_state    = TAP_RELEASE1;
                        first_tap_ms = it.now_ms;
                     end else begin
                        tap_state = TAP_IDLE;
                     end
                  end else if (tap_state == TAP_PRESS2) begin
                     doubled      = tap_near(it.pos_x, it.pos_y);
                     tap_state    = TAP_IDLE;
                     first_tap_ms = '0;
                  end
               end
               first = button_event(1'b1, EV_UP, !doubled);
               if (doubled) begin
                  second = button_event(1'b1, EV_DOUBLE, 1'b1);
                  return 2;
               end
            end
         end
         FUNC_TICK: begin
            lag = it.now_ms - repeat_at_ms;
            if (button_cfg.repeat_enable && button_held && lag != '0 && !lag[TIME_BITS-1]) begin
               repeat_at_ms = it.now_ms + REPEAT_EVERY_MS;
               first  = button_event(1'b0, EV_DOWN, 1'b0);
               second = button_event(1'b0, EV_UP, 1'b1);
               return 2;
            end
         end
         FUNC_RELEASE: begin
            button_held = 1'b0;
            first = button_event(1'b0, EV_UP, 1'b1);
         end
         default: ;
      endcase
      return 1;
   endfunction

   function automatic req_item_type request(input logic [FUNC_W-1:0] f,
                                            input logic [PID_W-1:0] pid,
                                            input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y,
                                            input logic [TIME_BITS-1:0] now);
      req_item_type it;
      it.func       = f;
      it.pointer_id = pid;
      it.pos_x      = x;
      it.pos_y      = y;
      it.now_ms     = now;
      return it;
   endfunction

   function automatic directed_row_type csr_row(input csr_reg_type idx,
                                                input logic [15:0] value);
      directed_row_type row;
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.value   = value;
      row.req     = '0;
      row.typed   = 1'b0;
      row.rsp     = '0;
      return row;
   endfunction

   function automatic directed_row_type req_row(input req_item_type it, input bit typed,
                                                input rsp_item_type rsp);
      directed_row_type row;
      row.is_csr  = 1'b0;
      row.reg_idx = CSR_RECT_LEFT;
      row.value   = '0;
      row.req     = it;
      row.typed   = typed;
      row.rsp     = rsp;
      return row;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] lo,
                                                        input logic [COORD_BITS-1:0] hi);
      if (lo > hi || $urandom_range(5) == 0)
         return COORD_BITS'($urandom_range(COORD_MAX));
      return COORD_BITS'($urandom_range(hi, lo));
   endfunction

   function automatic logic [COORD_BITS-1:0] drift_coord(input logic [COORD_BITS-1:0] c);
      return c + COORD_BITS'($urandom_range(1800)) - COORD_BITS'(900);
   endfunction

   task automatic offer_request(input req_item_type it, input bit typed,
                                input rsp_item_type typed_rsp);
      rsp_item_type first;
      rsp_item_type second;
      int unsigned count;
      while (!no_idle && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= it.func;
      req_if.pointer_id <= it.pointer_id;
      req_if.pos_x      <= it.pos_x;
      req_if.pos_y      <= it.pos_y;
      req_if.now_ms     <= it.now_ms;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      requests_sent++;
      count = qualify_request(it, first, second);
      if (typed) begin
         awaited_events.push_back(typed_rsp);
      end else begin
         awaited_events.push_back(first);
         if (count == 2)
            awaited_events.push_back(second);
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (awaited_events.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_RECT_LEFT:     button_cfg.rect_left     = value;
         CSR_RECT_TOP:      button_cfg.rect_top      = value;
         CSR_RECT_RIGHT:    button_cfg.rect_right    = value;
         CSR_RECT_BOTTOM:   button_cfg.rect_bottom   = value;
         CSR_BUTTON_CODE:   button_cfg.button_code   = value;
         CSR_REPEAT_ENABLE: button_cfg.repeat_enable = value[0];
         CSR_HIDDEN:        button_cfg.hidden        = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      wait_idle();
      write_csr(CSR_RECT_LEFT, c.rect_left);
      write_csr(CSR_RECT_TOP, c.rect_top);
      write_csr(CSR_RECT_RIGHT, c.rect_right);
      write_csr(CSR_RECT_BOTTOM, c.rect_bottom);
      write_csr(CSR_BUTTON_CODE, c.button_code);
      write_csr(CSR_REPEAT_ENABLE, 16'(c.repeat_enable));
      write_csr(CSR_HIDDEN, 16'(c.hidden));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned stop;
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      logic [PID_W-1:0] pid;
      logic [PID_W-1:0] up_pid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [FUNC_W-1:0] f;
      stop = requests_sent + count;
      while (requests_sent < stop) begin
         pick = $urandom_range(99);
         pid  = PID_W'($urandom_range(15));
         x    = pick_coord(button_cfg.rect_left, button_cfg.rect_right);
         y    = pick_coord(button_cfg.rect_top, button_cfg.rect_bottom);
         if (pick < 45) begin
            // tap, tap
            for (k = 0; k < 2; k++) begin
               wall_ms = wall_ms + TIME_BITS'($urandom_range(250)) - TIME_BITS'(10);
               offer_request(request(FUNC_DOWN, pid, drift_coord(x), drift_coord(y), wall_ms),
                             1'b0, '0);
               wall_ms = wall_ms + TIME_BITS'($urandom_range(250)) - TIME_BITS'(10);
               up_pid = ($urandom_range(9) == 0) ? PID_W'($urandom_range(15)) : pid;
               offer_request(request(FUNC_UP, up_pid, drift_coord(x), drift_coord(y), wall_ms),
                             1'b0, '0);
            end
         end else if (pick < 65) begin
            // press and hold through ticks
            wall_ms = wall_ms + TIME_BITS'($urandom_range(400));
            offer_request(request(FUNC_DOWN, pid, x, y, wall_ms), 1'b0, '0);
            n = $urandom_range(10, 2);
            for (k = 0; k < n; k++) begin
               wall_ms = wall_ms + TIME_BITS'($urandom_range(320));
               offer_request(request(FUNC_TICK, PID_W'($urandom_range(15)), x, y, wall_ms),
                             1'b0, '0);
            end
            f = ($urandom_range(2) == 0) ? FUNC_RELEASE : FUNC_UP;
            offer_request(request(f, pid, x, y, wall_ms), 1'b0, '0);
         end else if (pick < 80) begin
            case ($urandom_range(3))
               0: f = FUNC_MOVE;
               1: f = FUNC_UP;
               2: f = FUNC_TICK;
               default: f = FUNC_RELEASE;
            endcase
            wall_ms = wall_ms + TIME_BITS'($urandom_range(200));
            offer_request(request(f, pid, x, y, wall_ms), 1'b0, '0);
         end else begin
            if ($urandom_range(3) == 0)
               wall_ms = $urandom();
            offer_request(request(FUNC_W'($urandom_range(7)), pid,
                                  COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                                  ($urandom_range(1) == 0) ? wall_ms : $urandom()),
                          1'b0, '0);
         end
      end
   endtask

   // receiver
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_idle || $urandom_range(99) >= 28;
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_events.size() == 0) begin
            $error("unexpected result: event_res %0d", rsp_if.event_res);
            failures++;
         end else begin
            want = awaited_events.pop_front();
            if (rsp_if.handled !== want.handled) begin
               $error("handled: expected %0d, actual %0d", want.handled, rsp_if.handled);
               failures++;
            end
            if (rsp_if.event_res !== want.event_res) begin
               $error("event_res: expected %0d, actual %0d", want.event_res, rsp_if.event_res);
               failures++;
            end
            if (rsp_if.code !== want.code) begin
               $error("code: expected %04h, actual %04h", want.code, rsp_if.code);
               failures++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type setting;
      int i;
      req_if.valid      <= 1'b0;
      req_if.func       <= '0;
      req_if.pointer_id <= '0;
      req_if.pos_x      <= '0;
      req_if.pos_y      <= '0;
      req_if.now_ms     <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;

      button_cfg = '{rect_left: '0, rect_top: '0, rect_right: COORD_MAX,
                     rect_bottom: COORD_MAX, button_code: '0, repeat_enable: 1'b0,
                     hidden: 1'b0};
      button_held  = 1'b0;
      holder_pid   = '0;
      tap_state    = TAP_IDLE;
      first_tap_ms = '0;
      first_tap_x  = '0;
      first_tap_y  = '0;
      repeat_at_ms = '0;

      // out of reset: nothing held, code zero, full-screen area
      directed_rows.push_back(req_row(request(FUNC_MOVE, 4'hF, 16'hFFFF, 16'hFFFF,
                                              32'hFFFF_FFFF), 1'b1,
                                      fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h0, 16'h0000, 16'h0000, 32'd0),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_TICK, 4'h0, 16'h0000, 16'h0000, 32'd0),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_RELEASE, 4'h0, 16'h0000, 16'h0000, 32'd0),
                                      1'b1, fixed_event(1'b0, EV_UP, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_SPARE_LO, 4'h5, 16'h1234, 16'h5678, 32'd3),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_SPARE_HI, 4'hA, 16'hFFFF, 16'h0000, 32'd4),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h0, 16'h0000, 16'h0000, 32'd0),
                                      1'b1, fixed_event(1'b1, EV_DOWN, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'hF, 16'hFFFF, 16'hFFFF, 32'd10),
                                      1'b1, fixed_event(1'b1, EV_DOWN, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'hF, 16'hFFFF, 16'hFFFF, 32'd20),
                                      1'b0, '0));
      directed_rows.push_back(csr_row(CSR_RECT_LEFT, 16'h4000));
      directed_rows.push_back(csr_row(CSR_RECT_TOP, 16'h4000));
      directed_rows.push_back(csr_row(CSR_RECT_RIGHT, 16'hC000));
      directed_rows.push_back(csr_row(CSR_RECT_BOTTOM, 16'hC000));
      directed_rows.push_back(csr_row(CSR_BUTTON_CODE, 16'hFFFF));
      directed_rows.push_back(csr_row(CSR_REPEAT_ENABLE, 16'h0001));
      directed_rows.push_back(csr_row(CSR_HIDDEN, 16'h0000));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h3, 16'h3FFF, 16'h8000, 32'd1000),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h3, 16'h4000, 16'hC000, 32'd1000),
                                      1'b1, fixed_event(1'b1, EV_DOWN, 16'hFFFF)));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h2, 16'h4000, 16'hC000, 32'd1010),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      // repeat due strictly after the deadline
      directed_rows.push_back(req_row(request(FUNC_TICK, 4'h0, 16'h0, 16'h0, 32'd1500),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_TICK, 4'h0, 16'h0, 16'h0, 32'd1501),
                                      1'b0, '0));
      // double tap at the edge of the window and of the drift limit
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h3, 16'h4CCC, 16'hC000, 32'd1199),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h3, 16'h4000, 16'hC000, 32'd1398),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h3, 16'h4000, 16'hC000, 32'd1400),
                                      1'b0, '0));
      // hold across the time wrap, then hand over to a second pointer
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h1, 16'h8000, 16'h8000,
                                              32'hFFFF_FF00), 1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_TICK, 4'h0, 16'h0, 16'h0, 32'h0000_00F5),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h9, 16'h8000, 16'h8000, 32'h100),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h1, 16'h8000, 16'h8000, 32'h110),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h9, 16'hFFFF, 16'h0000, 32'h120),
                                      1'b0, '0));
      directed_rows.push_back(csr_row(CSR_HIDDEN, 16'h0001));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h0, 16'h8000, 16'h8000, 32'h130),
                                      1'b1, fixed_event(1'b0, EV_NONE, 16'h0000)));
      directed_rows.push_back(req_row(request(FUNC_RELEASE, 4'h0, 16'h0, 16'h0, 32'h140),
                                      1'b1, fixed_event(1'b0, EV_UP, 16'hFFFF)));
      directed_rows.push_back(csr_row(CSR_HIDDEN, 16'h0000));
      directed_rows.push_back(req_row(request(FUNC_DOWN, 4'h4, 16'h8000, 16'h8000, 32'h200),
                                      1'b0, '0));
      directed_rows.push_back(req_row(request(FUNC_UP, 4'h4, 16'h8CCD, 16'h8000, 32'h210),
                                      1'b0, '0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_csr) begin
            if (i == 0 || !directed_rows[i-1].is_csr)
               wait_idle();
            write_csr(directed_rows[i].reg_idx, directed_rows[i].value);
            if (i == directed_rows.size() - 1 || !directed_rows[i+1].is_csr)
               csr_wr_en <= 1'b0;
         end else begin
            offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
         end
      end

      wall_ms = $urandom();
      setting = '{rect_left: '0, rect_top: '0, rect_right: COORD_MAX, rect_bottom: COORD_MAX,
                  button_code: CODE_W'($urandom()), repeat_enable: 1'b1, hidden: 1'b0};
      apply_settings(setting);
      run_random(260);

      setting.rect_left   = COORD_BITS'($urandom_range(16'hF000));
      setting.rect_right  = setting.rect_left + COORD_BITS'(16'h0FFF);
      setting.rect_top    = COORD_BITS'($urandom_range(16'hF000));
      setting.rect_bottom = setting.rect_top + COORD_BITS'(16'h0FFF);
      setting.button_code = CODE_W'($urandom());
      apply_settings(setting);
      run_random(260);

      // inverted area: nothing is ever inside
      setting = '{rect_left: COORD_MAX, rect_top: '0, rect_right: '0, rect_bottom: COORD_MAX,
                  button_code: '0, repeat_enable: 1'b0, hidden: 1'b0};
      apply_settings(setting);
      run_random(120);

      // single-point area in the far corner
      setting = '{rect_left: COORD_MAX, rect_top: COORD_MAX, rect_right: COORD_MAX,
                  rect_bottom: COORD_MAX, button_code: CODE_W'($urandom()),
                  repeat_enable: 1'b1, hidden: 1'b0};
      apply_settings(setting);
      run_random(120);

      setting = '{rect_left: '0, rect_top: '0, rect_right: COORD_MAX, rect_bottom: COORD_MAX,
                  button_code: CODE_W'($urandom()), repeat_enable: 1'b1, hidden: 1'b1};
      apply_settings(setting);
      run_random(120);

      setting.rect_left   = COORD_BITS'($urandom_range(16'h7FFF));
      setting.rect_right  = COORD_BITS'($urandom_range(16'hFFFF, 16'h8000));
      setting.rect_top    = COORD_BITS'($urandom_range(16'h7FFF));
      setting.rect_bottom = COORD_BITS'($urandom_range(16'hFFFF, 16'h8000));
      setting.button_code = '1;
      setting.repeat_enable = 1'b0;
      setting.hidden = 1'b0;
      apply_settings(setting);
      run_random(260);

      // full speed across the time wrap, with one long receiver hold-off
      wall_ms = 32'hFFFF_F000;
      setting = '{rect_left: '0, rect_top: '0, rect_right: COORD_MAX, rect_bottom: COORD_MAX,
                  button_code: CODE_W'($urandom()), repeat_enable: 1'b1, hidden: 1'b0};
      apply_settings(setting);
      no_idle = 1'b1;
      hold_off_request = 1'b1;
      run_random(260);
      no_idle = 1'b0;

      req_if.valid <= 1'b0;
      while (awaited_events.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

[double_tap_button_detector_core.f]
hdl/dtb_pkg.sv
hdl/dtb_if.sv
hdl/dtb_req_stage.sv
hdl/dtb_qualifier.sv
hdl/dtb_rsp_fifo.sv
hdl/double_tap_button_detector_core.sv
hdl/dtb_checker.sv
tb/testbench.sv
